// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both sample on i_clk and are
// disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define VDIE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define VDIE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/vdie_pkg.sv =====
package vdie_pkg;

    // Input command codes
    localparam logic [1:0] CMD_EXEC = 2'd0;
    localparam logic [1:0] CMD_POS  = 2'd1;
    localparam logic [1:0] CMD_DOT  = 2'd2;
    localparam logic [1:0] CMD_RSVD = 2'd3;

    // Opcodes of the first instruction word
    localparam logic [3:0] OP_LONG_MAX = 4'd9;
    localparam logic [3:0] OP_HALT     = 4'd11;
    localparam logic [3:0] OP_CALL     = 4'd12;
    localparam logic [3:0] OP_RET      = 4'd13;
    localparam logic [3:0] OP_JUMP     = 4'd14;
    localparam logic [3:0] OP_SHORT    = 4'd15;

    // Flow codes of a result
    localparam logic [1:0] FLOW_NEXT = 2'd0;
    localparam logic [1:0] FLOW_JUMP = 2'd1;
    localparam logic [1:0] FLOW_RET  = 2'd2;
    localparam logic [1:0] FLOW_END  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_NUM    = 2'd0;
    localparam logic [1:0] CFG_DEN    = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam logic [9:0]  RST_NUM    = 10'd15;
    localparam logic [10:0] RST_DEN    = 11'd32;
    localparam logic [10:0] RST_HEIGHT = 11'd480;

    localparam logic [10:0] PCT_DEN   = 11'd100;
    localparam logic [3:0]  DOT_INTEN = 4'hF;
    localparam logic [4:0]  RST_GSHIFT = 5'd1;

    // Rounding divider: 26-bit product, two quotient bits per cycle
    localparam int RS_PROD_W = 26;
    localparam logic [3:0] RS_LAST_CYC = 4'd12;

    typedef enum logic [2:0] {
        K_NONE, K_POS, K_DOT, K_HALT, K_CALL, K_RET, K_JUMP, K_VEC
    } t_kind;

    // Classified item as it travels from front to back
    typedef struct packed {
        t_kind       kind;
        logic        instr;
        logic        start_run;
        logic [11:0] offset;
        logic [11:0] target;
        logic [7:0]  pct;
        logic [9:0]  pos_x;
        logic [9:0]  pos_y;
        logic [3:0]  gscale;
        logic [3:0]  local_shift;
        logic [9:0]  mag_y;
        logic        neg_y;
        logic [9:0]  mag_x;
        logic        neg_x;
        logic [3:0]  inten;
    } t_item;

    typedef struct packed {
        logic               line_valid;
        logic signed [15:0] x_start;
        logic signed [15:0] y_start;
        logic signed [15:0] x_end;
        logic signed [15:0] y_end;
        logic [3:0]         intensity;
        logic [1:0]         flow;
        logic [11:0]        flow_target;
    } t_result;

    typedef enum logic [2:0] {
        BK_IDLE, BK_DECODE, BK_START, BK_WAIT, BK_EMIT
    } t_bk_state;

    typedef enum logic [1:0] {
        RS_IDLE, RS_MUL, RS_DIV, RS_DONE
    } t_rs_state;

    // Scaling steps run by the back end
    typedef enum logic [2:0] {
        STEP_DY, STEP_DX, STEP_X0, STEP_Y0, STEP_X1, STEP_Y1
    } t_step;

    // Signed delta: magnitude shifted by local plus global shift
    function automatic logic [15:0] vd_delta(input logic [9:0] mag, input logic neg,
                                             input logic [3:0] lsh,
                                             input logic [4:0] gsh);
        logic signed [6:0] t;
        logic [6:0]  amt;
        logic [15:0] v;
        t   = signed'({3'b000, lsh}) + signed'({{2{gsh[4]}}, gsh});
        amt = 7'(7'd0 - t);
        if (t >= 7'sd16) begin
            v = 16'd0;
        end else if (!t[6]) begin
            v = {6'd0, mag} >> t[3:0];
        end else begin
            v = {6'd0, mag} << amt[3:0];
        end
        if (neg) begin
            v = 16'(16'd0 - v);
        end
        return v;
    endfunction

endpackage

// ===== design/vdie_rscale.sv =====
module vdie_rscale (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_v,
    input  logic [9:0]  i_num,
    input  logic [10:0] i_den,
    output logic        o_done,
    output logic [15:0] o_q
);

    vdie_pkg::t_rs_state r_state, n_state;
    logic                r_neg;
    logic [15:0]         r_mag;
    logic [9:0]          r_num;
    logic [10:0]         r_den;
    logic [vdie_pkg::RS_PROD_W-1:0] r_m, n_m;
    logic [10:0]         r_rem, n_rem;
    logic [3:0]          r_cnt;
    logic [11:0]         w_sh;
    logic [15:0]         w_q;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vdie_pkg::RS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_done  = 1'b0;
        unique case (r_state)
            vdie_pkg::RS_IDLE: if (i_start) n_state = vdie_pkg::RS_MUL;
            vdie_pkg::RS_MUL:  n_state = vdie_pkg::RS_DIV;
            vdie_pkg::RS_DIV:  if (r_cnt == vdie_pkg::RS_LAST_CYC) n_state = vdie_pkg::RS_DONE;
            vdie_pkg::RS_DONE: begin
                o_done  = 1'b1;
                n_state = vdie_pkg::RS_IDLE;
            end
            default: n_state = vdie_pkg::RS_IDLE;
        endcase
    end

    // two restoring divide steps per cycle
    always_comb begin
        n_m   = r_m;
        n_rem = r_rem;
        w_sh  = '0;
        for (int i = 0; i < 2; i++) begin
            w_sh = {n_rem, n_m[vdie_pkg::RS_PROD_W-1]};
            n_m  = {n_m[vdie_pkg::RS_PROD_W-2:0], 1'b0};
            if (w_sh >= {1'b0, r_den}) begin
                n_rem  = 11'(w_sh - {1'b0, r_den});
                n_m[0] = 1'b1;
            end else begin
                n_rem = w_sh[10:0];
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            vdie_pkg::RS_IDLE: begin
                r_neg <= i_v[15];
                r_mag <= i_v[15] ? 16'(16'd0 - i_v) : i_v;
                r_num <= i_num;
                r_den <= i_den;
            end
            vdie_pkg::RS_MUL: begin
                r_m   <= r_mag * r_num;
                r_rem <= '0;
                r_cnt <= '0;
            end
            vdie_pkg::RS_DIV: begin
                r_m   <= n_m;
                r_rem <= n_rem;
                r_cnt <= 4'(r_cnt + 4'd1);
            end
            default: ;
        endcase
    end

    // round up when remainder exceeds half the divisor, then apply sign
    assign w_q = 16'(r_m[15:0] + {15'd0, (r_rem > (r_den >> 1))});
    assign o_q = r_neg ? 16'(16'd0 - w_q) : w_q;

endmodule

// ===== design/vdie_front.sv =====
module vdie_front (
    input  logic           i_push,
    input  logic           i_q_full,
    input  logic [1:0]     i_cmd,
    input  logic [15:0]    i_word_first,
    input  logic [15:0]    i_word_second,
    input  logic [11:0]    i_instr_offset,
    input  logic           i_start_run,
    input  logic [7:0]     i_scale_percent,
    input  logic [9:0]     i_pos_x,
    input  logic [9:0]     i_pos_y,
    input  logic [3:0]     i_global_scale,
    output logic           o_q_push,
    output vdie_pkg::t_item o_item
);

    logic [3:0] w_op;

    assign w_op     = i_word_first[15:12];
    assign o_q_push = i_push && !i_q_full;

    // classify the beat
    always_comb begin
        o_item             = '0;
        o_item.kind        = vdie_pkg::K_NONE;
        o_item.offset      = i_instr_offset;
        o_item.target      = i_word_first[11:0];
        o_item.pct         = i_scale_percent;
        o_item.pos_x       = i_pos_x;
        o_item.pos_y       = i_pos_y;
        o_item.gscale      = i_global_scale;
        unique case (i_cmd)
            vdie_pkg::CMD_POS: o_item.kind = vdie_pkg::K_POS;
            vdie_pkg::CMD_DOT: o_item.kind = vdie_pkg::K_DOT;
            vdie_pkg::CMD_EXEC: begin
                o_item.instr     = 1'b1;
                o_item.start_run = i_start_run;
                if (w_op <= vdie_pkg::OP_LONG_MAX) begin
                    o_item.kind        = vdie_pkg::K_VEC;
                    o_item.local_shift = 4'(4'd9 - w_op);
                    o_item.mag_y       = i_word_first[9:0];
                    o_item.neg_y       = i_word_first[10];
                    o_item.mag_x       = i_word_second[9:0];
                    o_item.neg_x       = i_word_second[10];
                    o_item.inten       = i_word_second[15:12];
                end else begin
                    case (w_op)
                        vdie_pkg::OP_HALT: o_item.kind = vdie_pkg::K_HALT;
                        vdie_pkg::OP_CALL: o_item.kind = vdie_pkg::K_CALL;
                        vdie_pkg::OP_RET:  o_item.kind = vdie_pkg::K_RET;
                        vdie_pkg::OP_JUMP: o_item.kind = vdie_pkg::K_JUMP;
                        vdie_pkg::OP_SHORT: begin
                            o_item.kind        = vdie_pkg::K_VEC;
                            o_item.local_shift = 4'(4'd7 - {2'b00, i_word_first[3],
                                                            i_word_first[11]});
                            o_item.mag_y       = {i_word_first[9:8], 8'd0};
                            o_item.neg_y       = i_word_first[10];
                            o_item.mag_x       = {i_word_first[1:0], 8'd0};
                            o_item.neg_x       = i_word_first[2];
                            o_item.inten       = i_word_first[7:4];
                        end
                        default: o_item.kind = vdie_pkg::K_NONE;
                    endcase
                end
            end
            default: o_item.kind = vdie_pkg::K_NONE;
        endcase
    end

endmodule

// ===== design/vdie_queue.sv =====
module vdie_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vdie_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output vdie_pkg::t_item o_item
);

    vdie_pkg::t_item r_mem [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_mem[r_rptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            r_count <= 2'(r_count + {1'b0, i_push} - {1'b0, i_pop});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_item;
    end

endmodule

// ===== design/vdie_back.sv =====
module vdie_back #(
    parameter int ROM_ADDR_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  vdie_pkg::t_item   i_q_item,
    output logic              o_q_pop,
    input  logic [9:0]        i_num,
    input  logic [10:0]       i_den,
    input  logic [10:0]       i_height,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output vdie_pkg::t_result o_res
);

    localparam logic [11:0] RetMask =
        (ROM_ADDR_BITS >= 12) ? 12'hFFF : 12'((1 << ROM_ADDR_BITS) - 1);

    vdie_pkg::t_bk_state r_state, n_state;
    vdie_pkg::t_item     r_item;
    vdie_pkg::t_result   r_res;
    vdie_pkg::t_step     r_step;
    logic [15:0] r_beam_x, r_beam_y, r_old_x, r_old_y, r_dy;
    logic [4:0]  r_gshift;
    logic [11:0] r_ret_off;
    logic        r_ret_valid, r_first;

    logic        w_rs_start, w_rs_done, w_last;
    logic [15:0] w_rs_v, w_rs_q, w_pix_y;
    logic [9:0]  w_rs_num;
    logic [10:0] w_rs_den, w_den_eff;
    logic [1:0]  d_flow;
    logic [11:0] d_target;
    logic        d_rv, d_first, d_ret_load, w_rv_in, w_first_in;

    vdie_rscale u_rscale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rs_start),
        .i_v     (w_rs_v),
        .i_num   (w_rs_num),
        .i_den   (w_rs_den),
        .o_done  (w_rs_done),
        .o_q     (w_rs_q)
    );

    assign w_den_eff = (i_den == 11'd0) ? 11'd1 : i_den;
    assign w_pix_y   = 16'({5'd0, i_height} - w_rs_q);
    assign o_res     = r_res;

    // operand select for the shared rounding divider
    always_comb begin
        w_rs_num = i_num;
        w_rs_den = w_den_eff;
        case (r_step)
            vdie_pkg::STEP_DY: begin
                w_rs_v   = vdie_pkg::vd_delta(r_item.mag_y, r_item.neg_y,
                                              r_item.local_shift, r_gshift);
                w_rs_num = {2'b00, r_item.pct};
                w_rs_den = vdie_pkg::PCT_DEN;
            end
            vdie_pkg::STEP_DX: begin
                w_rs_v   = vdie_pkg::vd_delta(r_item.mag_x, r_item.neg_x,
                                              r_item.local_shift, r_gshift);
                w_rs_num = {2'b00, r_item.pct};
                w_rs_den = vdie_pkg::PCT_DEN;
            end
            vdie_pkg::STEP_X0: w_rs_v = r_old_x;
            vdie_pkg::STEP_Y0: w_rs_v = r_old_y;
            vdie_pkg::STEP_X1: w_rs_v = r_beam_x;
            default:           w_rs_v = r_beam_y;
        endcase
    end

    // program flow and return slot
    always_comb begin
        w_rv_in    = r_item.start_run ? 1'b0 : r_ret_valid;
        w_first_in = r_item.start_run | r_first;
        d_flow     = vdie_pkg::FLOW_NEXT;
        d_target   = '0;
        d_ret_load = 1'b0;
        d_rv       = w_rv_in;
        d_first    = 1'b0;
        case (r_item.kind)
            vdie_pkg::K_HALT: d_flow = vdie_pkg::FLOW_END;
            vdie_pkg::K_CALL: begin
                if (!w_first_in) begin
                    d_ret_load = 1'b1;
                    d_rv       = 1'b1;
                end
                d_flow   = vdie_pkg::FLOW_JUMP;
                d_target = r_item.target;
            end
            vdie_pkg::K_RET: begin
                if (w_rv_in) begin
                    d_flow   = vdie_pkg::FLOW_RET;
                    d_target = 12'(r_ret_off + 12'd1) & RetMask;
                    d_rv     = 1'b0;
                end else begin
                    d_flow = vdie_pkg::FLOW_END;
                end
            end
            vdie_pkg::K_JUMP: begin
                d_flow   = vdie_pkg::FLOW_JUMP;
                d_target = r_item.target;
            end
            default: ;
        endcase
        if (d_flow == vdie_pkg::FLOW_END) begin
            d_rv    = 1'b0;
            d_first = 1'b1;
        end
    end

    // last divider step of this item
    assign w_last = (r_step == vdie_pkg::STEP_DX && !r_res.line_valid) ||
                    (r_step == vdie_pkg::STEP_Y0 && r_item.kind == vdie_pkg::K_DOT) ||
                    (r_step == vdie_pkg::STEP_Y1);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vdie_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        w_rs_start  = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            vdie_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = vdie_pkg::BK_DECODE;
                end
            end
            vdie_pkg::BK_DECODE: begin
                if (r_item.kind == vdie_pkg::K_VEC || r_item.kind == vdie_pkg::K_DOT) begin
                    n_state = vdie_pkg::BK_START;
                end else begin
                    n_state = vdie_pkg::BK_EMIT;
                end
            end
            vdie_pkg::BK_START: begin
                w_rs_start = 1'b1;
                n_state    = vdie_pkg::BK_WAIT;
            end
            vdie_pkg::BK_WAIT: begin
                if (w_rs_done) n_state = w_last ? vdie_pkg::BK_EMIT : vdie_pkg::BK_START;
            end
            vdie_pkg::BK_EMIT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) n_state = vdie_pkg::BK_IDLE;
            end
            default: n_state = vdie_pkg::BK_IDLE;
        endcase
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beam_x    <= '0;
            r_beam_y    <= '0;
            r_gshift    <= vdie_pkg::RST_GSHIFT;
            r_ret_off   <= '0;
            r_ret_valid <= 1'b0;
            r_first     <= 1'b1;
        end else if (r_state == vdie_pkg::BK_DECODE) begin
            if (r_item.kind == vdie_pkg::K_POS) begin
                r_beam_x <= {6'd0, r_item.pos_x};
                r_beam_y <= {6'd0, r_item.pos_y};
                r_gshift <= r_item.gscale[3] ? 5'(5'd8 - {2'b00, r_item.gscale[2:0]})
                                             : 5'(5'd0 - {1'b0, r_item.gscale});
            end
            if (r_item.instr) begin
                r_first     <= d_first;
                r_ret_valid <= d_rv;
                if (d_ret_load) r_ret_off <= r_item.offset & RetMask;
            end
        end else if (r_state == vdie_pkg::BK_WAIT && w_rs_done &&
                     r_step == vdie_pkg::STEP_DX) begin
            r_beam_x <= 16'(r_beam_x + w_rs_q);
            r_beam_y <= 16'(r_beam_y + r_dy);
        end
    end

    // item payload and result assembly
    always_ff @(posedge i_clk) begin
        case (r_state)
            vdie_pkg::BK_IDLE: if (!i_q_empty) r_item <= i_q_item;
            vdie_pkg::BK_DECODE: begin
                r_res.x_start     <= '0;
                r_res.y_start     <= '0;
                r_res.x_end       <= '0;
                r_res.y_end       <= '0;
                r_res.flow        <= d_flow;
                r_res.flow_target <= d_target;
                r_old_x           <= r_beam_x;
                r_old_y           <= r_beam_y;
                if (r_item.kind == vdie_pkg::K_DOT) begin
                    r_res.line_valid <= 1'b1;
                    r_res.intensity  <= vdie_pkg::DOT_INTEN;
                    r_step           <= vdie_pkg::STEP_X0;
                end else begin
                    r_res.line_valid <= (r_item.kind == vdie_pkg::K_VEC) &&
                                        (r_item.inten != 4'd0);
                    r_res.intensity  <= (r_item.kind == vdie_pkg::K_VEC) ? r_item.inten
                                                                         : 4'd0;
                    r_step           <= vdie_pkg::STEP_DY;
                end
            end
            vdie_pkg::BK_WAIT: begin
                if (w_rs_done) begin
                    if (!w_last) r_step <= vdie_pkg::t_step'(3'(r_step + 3'd1));
                    case (r_step)
                        vdie_pkg::STEP_DY: r_dy <= w_rs_q;
                        vdie_pkg::STEP_X0: begin
                            r_res.x_start <= w_rs_q;
                            if (r_item.kind == vdie_pkg::K_DOT) r_res.x_end <= w_rs_q;
                        end
                        vdie_pkg::STEP_Y0: begin
                            r_res.y_start <= w_pix_y;
                            if (r_item.kind == vdie_pkg::K_DOT) r_res.y_end <= w_pix_y;
                        end
                        vdie_pkg::STEP_X1: r_res.x_end <= w_rs_q;
                        vdie_pkg::STEP_Y1: r_res.y_end <= w_pix_y;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== design/vector_display_instruction_engine_unit.sv =====
// Vector display instruction engine: takes classified beats (instruction, beam position
// with global scale, or dot) through a two-entry queue and returns exactly one result per
// beat. Position, halt, jump, call, return and ignored beats skip the divider in the
// back end. The work is done by the single shared rounding divider (multiply, then two
// quotient bits per cycle), used twice for the percent-scaled deltas and four times for
// pixel coordinates of a drawn vector, only for the deltas of a vector with zero
// intensity, and twice for the pixel coordinates of a dot. A finished result waits in
// the output register while the next beat is accepted into the queue.
`include "assert_macros.svh"

module vector_display_instruction_engine_unit #(
    parameter int ROM_ADDR_BITS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_cmd,
    input  logic [15:0]        i_word_first,
    input  logic [15:0]        i_word_second,
    input  logic [11:0]        i_instr_offset,
    input  logic               i_start_run,
    input  logic [7:0]         i_scale_percent,
    input  logic [9:0]         i_pos_x,
    input  logic [9:0]         i_pos_y,
    input  logic [3:0]         i_global_scale,
    output logic               empty,
    input  logic               pop,
    output logic               o_line_valid,
    output logic signed [15:0] o_x_start,
    output logic signed [15:0] o_y_start,
    output logic signed [15:0] o_x_end,
    output logic signed [15:0] o_y_end,
    output logic [3:0]         o_intensity,
    output logic [1:0]         o_flow,
    output logic [11:0]        o_flow_target,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [10:0]        i_cfg_data
);

    vdie_pkg::t_item   w_f_item, w_q_item;
    vdie_pkg::t_result w_res, r_out;
    logic w_q_push, w_q_pop, w_q_full, w_q_empty, w_res_valid, w_res_ready;
    logic r_out_valid;
    logic [9:0]  r_num;
    logic [10:0] r_den, r_height;
    logic w_coords_clear, w_target_clear;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num    <= vdie_pkg::RST_NUM;
            r_den    <= vdie_pkg::RST_DEN;
            r_height <= vdie_pkg::RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vdie_pkg::CFG_NUM:    r_num    <= i_cfg_data[9:0];
                vdie_pkg::CFG_DEN:    r_den    <= i_cfg_data;
                vdie_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vdie_front u_front (
        .i_push          (push),
        .i_q_full        (w_q_full),
        .i_cmd           (i_cmd),
        .i_word_first    (i_word_first),
        .i_word_second   (i_word_second),
        .i_instr_offset  (i_instr_offset),
        .i_start_run     (i_start_run),
        .i_scale_percent (i_scale_percent),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_global_scale  (i_global_scale),
        .o_q_push        (w_q_push),
        .o_item          (w_f_item)
    );

    vdie_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_f_item),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_item  (w_q_item)
    );

    vdie_back #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .i_num       (r_num),
        .i_den       (r_den),
        .i_height    (r_height),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    assign full = w_q_full;

    // output register
    assign w_res_ready = !r_out_valid || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) r_out <= w_res;
    end

    assign empty         = !r_out_valid;
    assign o_line_valid  = r_out.line_valid;
    assign o_x_start     = r_out.x_start;
    assign o_y_start     = r_out.y_start;
    assign o_x_end       = r_out.x_end;
    assign o_y_end       = r_out.y_end;
    assign o_intensity   = r_out.intensity;
    assign o_flow        = r_out.flow;
    assign o_flow_target = r_out.flow_target;

    // check terms
    assign w_coords_clear = (o_x_start == 16'sd0) && (o_y_start == 16'sd0) &&
                            (o_x_end == 16'sd0) && (o_y_end == 16'sd0) &&
                            (o_intensity == 4'd0);
    assign w_target_clear = (o_flow == vdie_pkg::FLOW_JUMP) ||
                            (o_flow == vdie_pkg::FLOW_RET) || (o_flow_target == 12'd0);

    // checks
    `VDIE_ASSERT_NXT(a_res_loaded, w_res_valid && w_res_ready, r_out_valid, "result beat lost")
    `VDIE_ASSERT_IMP(a_idle_coords, !empty && !o_line_valid, w_coords_clear, "coords set")
    `VDIE_ASSERT_IMP(a_idle_target, !empty, w_target_clear, "target without jump or return")

endmodule
